FILE: src/fsum_pkg.sv
// ============================================================================
// fsum_pkg
// Shared constants and types of the four-sum search core.
// ============================================================================
`default_nettype none

package fsum_pkg;

   localparam int STORE_DEPTH_DEF = 64;
   localparam int VALUE_BITS_DEF  = 32;
   localparam int MAX_EMIT_DEF    = 64;

   localparam int TARGET_BITS = 32;
   localparam int OUT_BITS    = 32;
   localparam int SUM_BITS    = 34;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_RUN  = 1'b1;

   typedef struct packed {
      logic lt;
      logic eq;
      logic gt;
   } fsum_cmp_type;

endpackage

`default_nettype wire

FILE: src/four_sum_two_pointer_search_core.sv
// ============================================================================
// four_sum_two_pointer_search_core
// Sorted store with insertion loads and a two-pointer four-sum search.
// ============================================================================
// A load beat inserts its value into the sorted store by shifting larger
// entries up one place per cycle; a load into an empty store is written
// directly, and one into a full store is dropped. A run beat walks two
// outer indices and two inner pointers over the store; every index or
// pointer step is a read of the store, then one pass through the shared
// subtract-and-compare unit, and the number of steps of a run grows with
// the cube of the element count. The store has a single write port and
// registered reads. The input is not ready while a load or a run is in
// progress, and the final result beat of a run is marked with tlast.
`default_nettype none

module four_sum_two_pointer_search_core
   import fsum_pkg::*;
#(
   parameter int STORE_DEPTH = STORE_DEPTH_DEF,
   parameter int VALUE_BITS  = VALUE_BITS_DEF,
   parameter int MAX_EMIT    = MAX_EMIT_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [31:0]            req_tdata,   // element_value
   input  wire logic [0:0]             req_tuser,   // command
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic      [4*OUT_BITS-1:0]  rsp_tdata,   // first, second, third, fourth value
   output logic      [2:0]             rsp_tuser,   // found, truncated, load_overflowed
   output logic                        rsp_tlast,   // last_of_run
   input  wire logic                   csr_wr_en,
   input  wire logic [TARGET_BITS-1:0] csr_wr_data  // target_sum
);

   localparam int AW = $clog2(STORE_DEPTH);
   localparam int CW = $clog2(STORE_DEPTH + 1);
   localparam int EW = $clog2(MAX_EMIT + 1);

   typedef enum logic [13:0] {
      ST_IDLE    = 14'b00000000000001,
      ST_INS_CMP = 14'b00000000000010,
      ST_INS_PUT = 14'b00000000000100,
      ST_I_RD    = 14'b00000000001000,
      ST_I_CHK   = 14'b00000000010000,
      ST_J_RD    = 14'b00000000100000,
      ST_J_CHK   = 14'b00000001000000,
      ST_P_RD    = 14'b00000010000000,
      ST_P_CMP   = 14'b00000100000000,
      ST_LO_RD   = 14'b00001000000000,
      ST_LO_CHK  = 14'b00010000000000,
      ST_HI_RD   = 14'b00100000000000,
      ST_HI_CHK  = 14'b01000000000000,
      ST_DONE    = 14'b10000000000000
   } state_type;

   state_type                      state_ff, state_in;
   logic [CW-1:0]                  count_ff, count_in;
   logic                           ovf_ff, ovf_in;
   logic signed [TARGET_BITS-1:0]  target_ff, target_in;
   logic signed [VALUE_BITS-1:0]   val_ff, val_in;
   logic [CW-1:0]                  p_ff, p_in;
   logic [CW-1:0]                  i_ff, i_in;
   logic [CW-1:0]                  j_ff, j_in;
   logic [CW-1:0]                  lo_ff, lo_in;
   logic [CW-1:0]                  hi_ff, hi_in;
   logic [EW-1:0]                  emit_ff, emit_in;
   logic                           more_ff, more_in;
   logic signed [VALUE_BITS-1:0]   ai_ff, ai_in;
   logic signed [VALUE_BITS-1:0]   aj_ff, aj_in;
   logic signed [SUM_BITS-1:0]     tmi_ff, tmi_in;
   logic signed [SUM_BITS-1:0]     rest_ff, rest_in;
   logic                           pend_valid_ff, pend_valid_in;
   logic signed [VALUE_BITS-1:0]   pend_a_ff, pend_a_in;
   logic signed [VALUE_BITS-1:0]   pend_b_ff, pend_b_in;
   logic signed [VALUE_BITS-1:0]   pend_c_ff, pend_c_in;
   logic signed [VALUE_BITS-1:0]   pend_d_ff, pend_d_in;
   logic                           rsp_tvalid_ff, rsp_tvalid_in;
   logic [4*OUT_BITS-1:0]          rsp_tdata_ff, rsp_tdata_in;
   logic [2:0]                     rsp_tuser_ff, rsp_tuser_in;
   logic                           rsp_tlast_ff, rsp_tlast_in;

   logic                           rd_en;
   logic [AW-1:0]                  rd_addr_a;
   logic [AW-1:0]                  rd_addr_b;
   logic signed [VALUE_BITS-1:0]   rd_a;
   logic signed [VALUE_BITS-1:0]   rd_b;
   logic                           wr_en;
   logic [AW-1:0]                  wr_addr;
   logic signed [VALUE_BITS-1:0]   wr_data;

   logic signed [SUM_BITS-1:0]     au_x;
   logic signed [SUM_BITS-1:0]     au_y;
   logic signed [SUM_BITS-1:0]     au_z;
   logic signed [SUM_BITS-1:0]     au_diff;
   fsum_cmp_type                   au_cmp;

   logic                           out_free;
   logic                           push;
   logic                           push_found;
   logic                           push_last;
   logic                           push_trunc;
   logic signed [VALUE_BITS-1:0]   req_value;

   fsum_store #(
      .DEPTH (STORE_DEPTH),
      .WIDTH (VALUE_BITS)
   ) u_store (
      .clock     (clock),
      .rd_en     (rd_en),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_a),
      .rd_data_b (rd_b),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data)
   );

   fsum_alu u_alu (
      .au_x    (au_x),
      .au_y    (au_y),
      .au_z    (au_z),
      .au_diff (au_diff),
      .au_cmp  (au_cmp)
   );

   assign req_value  = req_tdata[VALUE_BITS-1:0];
   assign req_tready = (state_ff == ST_IDLE);
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      ovf_in        = ovf_ff;
      target_in     = csr_wr_en ? csr_wr_data : target_ff;
      val_in        = val_ff;
      p_in          = p_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      emit_in       = emit_ff;
      more_in       = more_ff;
      ai_in         = ai_ff;
      aj_in         = aj_ff;
      tmi_in        = tmi_ff;
      rest_in       = rest_ff;
      pend_valid_in = pend_valid_ff;
      pend_a_in     = pend_a_ff;
      pend_b_in     = pend_b_ff;
      pend_c_in     = pend_c_ff;
      pend_d_in     = pend_d_ff;
      rd_en         = 1'b0;
      rd_addr_a     = '0;
      rd_addr_b     = '0;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = val_ff;
      au_x          = '0;
      au_y          = '0;
      au_z          = '0;
      push          = 1'b0;
      push_found    = 1'b0;
      push_last     = 1'b0;
      push_trunc    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser[0] == CMD_RUN) begin
                  i_in          = '0;
                  emit_in       = '0;
                  more_in       = 1'b0;
                  pend_valid_in = 1'b0;
                  state_in      = ST_I_RD;
               end else if (count_ff == CW'(STORE_DEPTH)) begin
                  ovf_in = 1'b1;
               end else if (count_ff == '0) begin
                  wr_en    = 1'b1;
                  wr_addr  = '0;
                  wr_data  = req_value;
                  count_in = count_ff + CW'(1);
               end else begin
                  val_in    = req_value;
                  p_in      = count_ff;
                  rd_en     = 1'b1;
                  rd_addr_a = AW'(count_ff - CW'(1));
                  state_in  = ST_INS_CMP;
               end
            end
         end
         ST_INS_CMP: begin
            au_x = SUM_BITS'(rd_a);
            au_z = SUM_BITS'(val_ff);
            if (au_cmp.gt) begin
               wr_en   = 1'b1;
               wr_addr = p_ff[AW-1:0];
               wr_data = rd_a;
               if (p_ff == CW'(1)) begin
                  p_in     = '0;
                  state_in = ST_INS_PUT;
               end else begin
                  rd_en     = 1'b1;
                  rd_addr_a = AW'(p_ff - CW'(2));
                  p_in      = p_ff - CW'(1);
               end
            end else begin
               wr_en    = 1'b1;
               wr_addr  = p_ff[AW-1:0];
               count_in = count_ff + CW'(1);
               state_in = ST_IDLE;
            end
         end
         ST_INS_PUT: begin
            wr_en    = 1'b1;
            wr_addr  = '0;
            count_in = count_ff + CW'(1);
            state_in = ST_IDLE;
         end
         ST_I_RD: begin
            if ({1'b0, i_ff} + (CW+1)'(3) < {1'b0, count_ff}) begin
               rd_en     = 1'b1;
               rd_addr_a = i_ff[AW-1:0];
               rd_addr_b = AW'(i_ff - CW'(1));
               state_in  = ST_I_CHK;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_I_CHK: begin
            au_x = SUM_BITS'(rd_a);
            au_z = SUM_BITS'(rd_b);
            if (i_ff != '0 && au_cmp.eq) begin
               i_in     = i_ff + CW'(1);
               state_in = ST_I_RD;
            end else begin
               ai_in    = rd_a;
               j_in     = i_ff + CW'(1);
               state_in = ST_J_RD;
            end
         end
         ST_J_RD: begin
            au_x   = SUM_BITS'(target_ff);
            au_y   = SUM_BITS'(ai_ff);
            tmi_in = au_diff;
            if ({1'b0, j_ff} + (CW+1)'(2) < {1'b0, count_ff}) begin
               rd_en     = 1'b1;
               rd_addr_a = j_ff[AW-1:0];
               rd_addr_b = AW'(j_ff - CW'(1));
               state_in  = ST_J_CHK;
            end else begin
               i_in     = i_ff + CW'(1);
               state_in = ST_I_RD;
            end
         end
         ST_J_CHK: begin
            au_x = SUM_BITS'(rd_a);
            au_z = SUM_BITS'(rd_b);
            if (j_ff != i_ff + CW'(1) && au_cmp.eq) begin
               j_in     = j_ff + CW'(1);
               state_in = ST_J_RD;
            end else begin
               aj_in    = rd_a;
               lo_in    = j_ff + CW'(1);
               hi_in    = count_ff - CW'(1);
               state_in = ST_P_RD;
            end
         end
         ST_P_RD: begin
            au_x    = tmi_ff;
            au_y    = SUM_BITS'(aj_ff);
            rest_in = au_diff;
            if (lo_ff < hi_ff) begin
               rd_en     = 1'b1;
               rd_addr_a = lo_ff[AW-1:0];
               rd_addr_b = hi_ff[AW-1:0];
               state_in  = ST_P_CMP;
            end else begin
               j_in     = j_ff + CW'(1);
               state_in = ST_J_RD;
            end
         end
         ST_P_CMP: begin
            au_x = rest_ff;
            au_y = SUM_BITS'(rd_a);
            au_z = SUM_BITS'(rd_b);
            if (au_cmp.gt) begin
               lo_in    = lo_ff + CW'(1);
               state_in = ST_P_RD;
            end else if (au_cmp.lt) begin
               hi_in    = hi_ff - CW'(1);
               state_in = ST_P_RD;
            end else if (emit_ff >= EW'(MAX_EMIT)) begin
               more_in  = 1'b1;
               state_in = ST_DONE;
            end else if (!pend_valid_ff || out_free) begin
               push          = pend_valid_ff;
               push_found    = 1'b1;
               pend_valid_in = 1'b1;
               pend_a_in     = ai_ff;
               pend_b_in     = aj_ff;
               pend_c_in     = rd_a;
               pend_d_in     = rd_b;
               emit_in       = emit_ff + EW'(1);
               lo_in         = lo_ff + CW'(1);
               state_in      = ST_LO_RD;
            end
         end
         ST_LO_RD: begin
            if (lo_ff < hi_ff) begin
               rd_en     = 1'b1;
               rd_addr_a = lo_ff[AW-1:0];
               rd_addr_b = AW'(lo_ff - CW'(1));
               state_in  = ST_LO_CHK;
            end else begin
               hi_in    = hi_ff - CW'(1);
               state_in = ST_HI_RD;
            end
         end
         ST_LO_CHK: begin
            au_x = SUM_BITS'(rd_a);
            au_z = SUM_BITS'(rd_b);
            if (au_cmp.eq) begin
               lo_in    = lo_ff + CW'(1);
               state_in = ST_LO_RD;
            end else begin
               hi_in    = hi_ff - CW'(1);
               state_in = ST_HI_RD;
            end
         end
         ST_HI_RD: begin
            if (lo_ff < hi_ff) begin
               rd_en     = 1'b1;
               rd_addr_a = hi_ff[AW-1:0];
               rd_addr_b = AW'(hi_ff + CW'(1));
               state_in  = ST_HI_CHK;
            end else begin
               state_in = ST_P_RD;
            end
         end
         ST_HI_CHK: begin
            au_x = SUM_BITS'(rd_a);
            au_z = SUM_BITS'(rd_b);
            if (au_cmp.eq) begin
               hi_in    = hi_ff - CW'(1);
               state_in = ST_HI_RD;
            end else begin
               state_in = ST_P_RD;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               push          = 1'b1;
               push_found    = pend_valid_ff;
               push_last     = 1'b1;
               push_trunc    = more_ff;
               pend_valid_in = 1'b0;
               count_in      = '0;
               ovf_in        = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      rsp_tlast_in  = rsp_tlast_ff;
      if (push) begin
         rsp_tvalid_in = 1'b1;
         rsp_tlast_in  = push_last;
         rsp_tuser_in  = {ovf_ff, push_trunc, push_found};
         if (push_found) begin
            rsp_tdata_in = {OUT_BITS'(pend_d_ff), OUT_BITS'(pend_c_ff),
                            OUT_BITS'(pend_b_ff), OUT_BITS'(pend_a_ff)};
         end else begin
            rsp_tdata_in = '0;
         end
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         ovf_ff        <= 1'b0;
         target_ff     <= '0;
         emit_ff       <= '0;
         more_ff       <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         ovf_ff        <= ovf_in;
         target_ff     <= target_in;
         emit_ff       <= emit_in;
         more_ff       <= more_in;
         pend_valid_ff <= pend_valid_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff       <= val_in;
      p_ff         <= p_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      ai_ff        <= ai_in;
      aj_ff        <= aj_in;
      tmi_ff       <= tmi_in;
      rest_ff      <= rest_in;
      pend_a_ff    <= pend_a_in;
      pend_b_ff    <= pend_b_in;
      pend_c_ff    <= pend_c_in;
      pend_d_ff    <= pend_d_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
      rsp_tlast_ff <= rsp_tlast_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tlast  = rsp_tlast_ff;

   // A result beat is never loaded over one that has not yet been taken.
   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      push |-> out_free)
      else $error("result beat overwritten before it was taken");

   // The element count never exceeds the store depth.
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(STORE_DEPTH))
      else $error("element count beyond store depth");

   // While a pair is compared, both pointers lie inside the loaded part.
   a_pointer_range : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_P_CMP) |-> (lo_ff < hi_ff && hi_ff < count_ff))
      else $error("search pointers outside the loaded elements");

   // The final beat of a run leaves the store empty and the overflow flag clear.
   a_run_clears : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && out_free) |=> (count_ff == '0 && !ovf_ff))
      else $error("store not cleared after a run");

endmodule

`default_nettype wire

FILE: src/fsum_store.sv
// ============================================================================
// fsum_store
// Sorted element store: one write port and two registered read ports.
// ============================================================================
`default_nettype none

module fsum_store #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic      [WIDTH-1:0]         rd_data_a,
   output logic      [WIDTH-1:0]         rd_data_b,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_a <= mem[rd_addr_a];
         rd_data_b <= mem[rd_addr_b];
      end
   end

endmodule

`default_nettype wire

FILE: src/fsum_alu.sv
// ============================================================================
// fsum_alu
// Shared subtract-and-compare unit: forms x - y and compares it with z.
// ============================================================================
`default_nettype none

module fsum_alu
   import fsum_pkg::*;
(
   input  wire logic signed [SUM_BITS-1:0] au_x,
   input  wire logic signed [SUM_BITS-1:0] au_y,
   input  wire logic signed [SUM_BITS-1:0] au_z,
   output logic signed      [SUM_BITS-1:0] au_diff,
   output fsum_cmp_type                    au_cmp
);

   always_comb begin
      au_diff   = au_x - au_y;
      au_cmp.lt = au_diff < au_z;
      au_cmp.eq = au_diff == au_z;
      au_cmp.gt = au_diff > au_z;
   end

endmodule

`default_nettype wire
